// File: rtl/core/ased_pkg.sv
// Shared types and constants for the approximate substring edit distance unit.
// No dependencies; used by ased_ctrl, ased_datapath and the top level.
`default_nettype none
package ased_pkg;

  localparam int CELL_W     = 6;
  localparam int CELL_MAX   = 63;
  localparam int PAT_BYTES  = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 6;
  localparam int END_W      = 16;
  localparam int START_W    = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_0_7    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_8_15   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_16_23  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_24_31  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;   // latch beat, bump position, restart column sweep
    logic step;    // update one row of the column
    logic finish;  // fold bottom cell into best, load result register
  } ased_cmd_t;

  typedef struct packed {
    logic sweep_done;  // current row is the last one
    logic out_hold;    // result register full and not being taken
  } ased_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/approx_substring_edit_distance_unit.sv
// Approximate substring matcher: streams text bytes against a pattern of up
// to MAX_PATTERN bytes and reports the best semi-global edit distance per byte.
// Depends on ased_pkg, ased_ctrl and ased_datapath.
//
// One result beat comes out for every text beat, carrying the least bottom-row
// distance of the current text, its 1-based end position (latest on ties), the
// end minus the pattern length, a match flag (5 * distance < length) and a copy
// of the last marker; after a last beat the column, best and position reset.
// Each text beat is accepted, then a single cell unit walks the distance column
// one row per cycle over all MAX_PATTERN rows, then a finish step folds the
// bottom cell into the running best and loads the result register, waiting
// while the previous result is held. A new beat is accepted while the
// previous result still waits on out_ready. Configuration writes take effect at
// once and must only be issued while no beat is in flight.
`default_nettype none
module approx_substring_edit_distance_unit #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_write_en,
  input  wire  [ased_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [ased_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [7:0]                          in_text_byte,
  input  wire                                 in_text_last,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [ased_pkg::CELL_W-1:0]         out_best_distance,
  output logic [ased_pkg::END_W-1:0]          out_end_position,
  output logic signed [ased_pkg::START_W-1:0] out_start_position,
  output logic                                out_is_match,
  output logic                                out_text_done
);

  ased_pkg::ased_cmd_t cmd;
  ased_pkg::ased_sts_t sts;

  ased_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ased_datapath #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_text_byte       (in_text_byte),
    .in_text_last       (in_text_last),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_best_distance  (out_best_distance),
    .out_end_position   (out_end_position),
    .out_start_position (out_start_position),
    .out_is_match       (out_is_match),
    .out_text_done      (out_text_done)
  );

endmodule
`default_nettype wire

// File: rtl/core/ased_ctrl.sv
// Sequencer for the edit distance unit: accept, row sweep, finish.
// Depends on ased_pkg.
`default_nettype none
module ased_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  ased_pkg::ased_sts_t sts,
  output ased_pkg::ased_cmd_t cmd
);

  ased_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ased_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ased_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ased_pkg::ST_SWEEP;
        end
      end
      ased_pkg::ST_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ased_pkg::ST_FINISH;
        end
      end
      ased_pkg::ST_FINISH: begin
        // wait until the previous result has left
        if (!sts.out_hold) begin
          cmd.finish = 1'b1;
          state_nxt  = ased_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ased_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/ased_datapath.sv
// Datapath: pattern registers, distance column, one-cell update unit,
// best tracking and result register. Depends on ased_pkg.
`default_nettype none
module ased_datapath #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_write_en,
  input  wire  [ased_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [ased_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire  [7:0]                            in_text_byte,
  input  wire                                   in_text_last,
  input  wire  ased_pkg::ased_cmd_t             cmd,
  output ased_pkg::ased_sts_t                   sts,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [ased_pkg::CELL_W-1:0]           out_best_distance,
  output logic [ased_pkg::END_W-1:0]            out_end_position,
  output logic signed [ased_pkg::START_W-1:0]   out_start_position,
  output logic                                  out_is_match,
  output logic                                  out_text_done
);

  localparam int ROW_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int M_W   = $clog2(MAX_PATTERN + 1);
  localparam int EXT_W = (POSITION_BITS > ased_pkg::START_W) ? POSITION_BITS
                                                             : ased_pkg::START_W;
  localparam int CW    = ased_pkg::CELL_W;

  // configuration
  logic [ased_pkg::LEN_W-1:0]          len_r;
  logic [8*ased_pkg::PAT_BYTES-1:0]    pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= ased_pkg::LEN_W'(1);
      pat_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ased_pkg::CFG_PATTERN_LENGTH: len_r <= cfg_data[ased_pkg::LEN_W-1:0];
        ased_pkg::CFG_PATTERN_0_7:    pat_r[63:0]    <= cfg_data;
        ased_pkg::CFG_PATTERN_8_15:   pat_r[127:64]  <= cfg_data;
        ased_pkg::CFG_PATTERN_16_23:  pat_r[191:128] <= cfg_data;
        ased_pkg::CFG_PATTERN_24_31:  pat_r[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pattern length in use, clamped to 1..MAX_PATTERN
  logic [M_W-1:0]   m_sel;
  logic [ROW_W-1:0] bottom_row;
  always_comb begin
    if (len_r == '0) begin
      m_sel = M_W'(1);
    end else if (7'(len_r) > 7'(MAX_PATTERN)) begin
      m_sel = M_W'(MAX_PATTERN);
    end else begin
      m_sel = M_W'(len_r);
    end
    bottom_row = ROW_W'(m_sel - M_W'(1));
  end

  // per-beat and per-text state
  logic [7:0]               byte_r;
  logic                     last_r;
  logic [ROW_W-1:0]         row_r;
  logic [CW-1:0]            diag_r;
  logic [CW-1:0]            above_r;
  logic [CW-1:0]            bottom_r;
  logic [CW-1:0]            col_r [MAX_PATTERN];
  logic [CW-1:0]            best_r;
  logic [POSITION_BITS-1:0] best_end_r;
  logic [POSITION_BITS-1:0] count_r;

  // one cell of the column
  logic [6:0]    row_ext;
  logic [7:0]    pat_byte;
  logic [CW-1:0] old_cell;
  logic [CW:0]   c_sub, c_ins, c_del, c_min;
  logic [CW-1:0] cell_new;

  always_comb begin
    row_ext  = 7'(row_r);
    pat_byte = (row_ext < 7'(ased_pkg::PAT_BYTES)) ? pat_r[row_ext[4:0]*8 +: 8] : 8'd0;
    old_cell = col_r[row_r];
    c_sub    = (CW+1)'(diag_r) + ((pat_byte == byte_r) ? (CW+1)'(0) : (CW+1)'(1));
    c_ins    = (CW+1)'(above_r) + (CW+1)'(1);
    c_del    = (CW+1)'(old_cell) + (CW+1)'(1);
    c_min    = c_sub;
    if (c_ins < c_min) c_min = c_ins;
    if (c_del < c_min) c_min = c_del;
    cell_new = (c_min > (CW+1)'(ased_pkg::CELL_MAX)) ? CW'(ased_pkg::CELL_MAX)
                                                    : c_min[CW-1:0];
  end

  assign sts.sweep_done = (row_r == ROW_W'(MAX_PATTERN - 1));
  assign sts.out_hold   = out_valid && !out_ready;

  // best update at finish
  logic                     take_bottom;
  logic [CW-1:0]            best_nxt;
  logic [POSITION_BITS-1:0] best_end_nxt;
  logic [EXT_W-1:0]         end_ext;
  logic [8:0]               best_x5;
  logic                     clear_text;

  always_comb begin
    take_bottom  = (bottom_r <= best_r);
    best_nxt     = take_bottom ? bottom_r : best_r;
    best_end_nxt = take_bottom ? count_r : best_end_r;
    end_ext      = EXT_W'(best_end_nxt);
    best_x5      = (9'(best_nxt) << 2) + 9'(best_nxt);
    clear_text   = cmd.finish && last_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      byte_r <= in_text_byte;
      last_r <= in_text_last;
    end
    if (cmd.start) begin
      row_r   <= '0;
      diag_r  <= '0;
      above_r <= '0;
    end else if (cmd.step) begin
      row_r   <= row_r + ROW_W'(1);
      diag_r  <= old_cell;
      above_r <= cell_new;
      if (row_r == bottom_row) bottom_r <= cell_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (!rst_n || clear_text) begin
        col_r[i] <= (i + 1 > ased_pkg::CELL_MAX) ? CW'(ased_pkg::CELL_MAX) : CW'(i + 1);
      end else if (cmd.step && row_r == ROW_W'(i)) begin
        col_r[i] <= cell_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_text) begin
      best_r     <= CW'(ased_pkg::CELL_MAX);
      best_end_r <= '0;
      count_r    <= '0;
    end else begin
      if (cmd.start && count_r != '1) count_r <= count_r + POSITION_BITS'(1);
      if (cmd.finish) begin
        best_r     <= best_nxt;
        best_end_r <= best_end_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_best_distance  <= best_nxt;
      out_end_position   <= end_ext[ased_pkg::END_W-1:0];
      out_start_position <= end_ext[ased_pkg::START_W-1:0] - ased_pkg::START_W'(m_sel);
      out_is_match       <= (best_x5 < 9'(m_sel));
      out_text_done      <= last_r;
    end
  end

endmodule
`default_nettype wire

// File: sim/approx_substring_edit_distance_unit_tb.sv
// Self-checking testbench for approx_substring_edit_distance_unit:
// directed table, then random texts checked against a column model.
// Depends on ased_pkg and the unit's RTL.
`timescale 1ns / 100ps
module approx_substring_edit_distance_unit_tb;

  localparam int IDX_W = ased_pkg::CFG_IDX_W;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BEATS = 750;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [IDX_W-1:0] CFG_UNMAPPED_FIRST = 3'd5;
  localparam logic [IDX_W-1:0] CFG_UNMAPPED_LAST = 3'd7;
  localparam logic [16:0] START_MINUS_31 = 17'h1FFE1;
  localparam logic [63:0] DIR_W0 = 64'h4847_4645_4443_4241;
  localparam logic [63:0] DIR_W1 = 64'h504F_4E4D_4C4B_4A49;
  localparam logic [63:0] DIR_W2 = 64'h5857_5655_5453_5251;
  localparam logic [63:0] DIR_W3 = 64'hFF00_5A5A_5A5A_5A59;

  typedef struct packed {
    logic [ased_pkg::CELL_W-1:0]  distance;
    logic [ased_pkg::END_W-1:0]   end_pos;
    logic [ased_pkg::START_W-1:0] origin_pos;
    logic                         is_match;
    logic                         done;
  } match_result_t;

  typedef enum bit {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [IDX_W-1:0]     idx;
    logic [63:0]          data;
    logic [7:0]           ch;
    logic                 last;
    bit                   typed;
    match_result_t        exp;
  } vector_row_t;

  logic clk;
  logic rst_n;
  logic cfg_write_en;
  logic [IDX_W-1:0] cfg_index;
  logic [ased_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_text_byte;
  logic in_text_last;
  logic out_valid;
  logic out_ready;
  logic [ased_pkg::CELL_W-1:0] out_best_distance;
  logic [ased_pkg::END_W-1:0] out_end_position;
  logic signed [ased_pkg::START_W-1:0] out_start_position;
  logic out_is_match;
  logic out_text_done;

  // model of the matcher
  logic [5:0]   pat_len;
  logic [255:0] pat_bits;
  logic [5:0]   col_cost [32];
  logic [5:0]   best_cost;
  logic [15:0]  best_end;
  logic [15:0]  char_cnt;

  match_result_t expected_results [$];
  vector_row_t   directed_rows [$];
  logic [7:0]    alphabet [4];
  bit            idle_on;
  int            rx_hold_request;
  int            mismatch_count;
  int            beats_sent;
  int            cycle_count;

  approx_substring_edit_distance_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_text_byte(in_text_byte),
    .in_text_last(in_text_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_best_distance(out_best_distance),
    .out_end_position(out_end_position),
    .out_start_position(out_start_position),
    .out_is_match(out_is_match),
    .out_text_done(out_text_done)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int used_length();
    if (pat_len == 0) return 1;
    if (pat_len > 32) return 32;
    return pat_len;
  endfunction

  function automatic void clear_text();
    int i;
    for (i = 0; i < 32; i++) col_cost[i] = 6'(i + 1);
    best_cost = 6'h3F;
    best_end = '0;
    char_cnt = '0;
  endfunction

  function automatic match_result_t advance_matcher(logic [7:0] ch, logic last);
    int i;
    int m;
    logic [6:0] diag, above, old, v;
    match_result_t r;
    m = used_length();
    if (char_cnt != 16'hFFFF) char_cnt++;
    diag = '0;
    above = '0;
    for (i = 0; i < 32; i++) begin
      old = {1'b0, col_cost[i]};
      v = diag + ((pat_bits[i*8 +: 8] == ch) ? 7'd0 : 7'd1);
      if (above + 7'd1 < v) v = above + 7'd1;
      if (old + 7'd1 < v) v = old + 7'd1;
      if (v > 7'd63) v = 7'd63;
      col_cost[i] = v[5:0];
      diag = old;
      above = v;
    end
    // ties go to the later position
    if (col_cost[m-1] <= best_cost) begin
      best_cost = col_cost[m-1];
      best_end = char_cnt;
    end
    r.distance = best_cost;
    r.end_pos = best_end;
    r.origin_pos = {1'b0, best_end} - 17'(m);
    r.is_match = (5 * int'(best_cost)) < m;
    r.done = last;
    if (last) clear_text();
    return r;
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return alphabet[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  function automatic void add_write(logic [IDX_W-1:0] idx, logic [63:0] data);
    vector_row_t row;
    row = '{ROW_WRITE, idx, data, 8'h00, 1'b0, 1'b0, '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_beat(logic [7:0] ch, logic last, bit typed, match_result_t exp);
    vector_row_t row;
    row = '{ROW_BEAT, '0, '0, ch, last, typed, exp};
    directed_rows.push_back(row);
  endfunction

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [63:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    if (idx == ased_pkg::CFG_PATTERN_LENGTH) pat_len = data[5:0];
    else if (idx <= ased_pkg::CFG_PATTERN_24_31) pat_bits[(int'(idx) - 1) * 64 +: 64] = data;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_beat(input logic [7:0] ch, input logic last, input bit typed,
                           input match_result_t typed_exp);
    int gap;
    match_result_t r;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= ch;
    in_text_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = advance_matcher(ch, last);
    expected_results.push_back(typed ? typed_exp : r);
    beats_sent++;
  endtask

  // result side: random stalls, one long hold-off on request, checking
  initial begin
    int stall;
    int hold;
    match_result_t got;
    match_result_t want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_request > 0) begin
        hold = rx_hold_request;
        rx_hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {out_best_distance, out_end_position, out_start_position, out_is_match,
             out_text_done};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result beat with nothing expected: dist=%0d end=%0d", $realtime,
                   got.distance, got.end_pos);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch exp dist=%0d end=%0d start=%0d match=%b done=%b",
                      " | got dist=%0d end=%0d start=%0d match=%b done=%b"},
                     $realtime, want.distance, want.end_pos, $signed(want.origin_pos),
                     want.is_match, want.done, got.distance, got.end_pos,
                     $signed(got.origin_pos), got.is_match, got.done);
        end
      end
    end
  end

  initial begin
    int k;
    int j;
    int phase;
    int ntexts;
    int t;
    int m_eff;
    int sel;
    bit truncate;
    bit small_alpha;
    logic [5:0] len_sel;
    logic [63:0] word;
    logic [7:0] pb;
    logic [7:0] text_q [$];
    vector_row_t row;

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_text_last = 1'b0;
    out_ready = 1'b0;
    idle_on = 1'b1;
    rx_hold_request = 0;
    mismatch_count = 0;
    beats_sent = 0;
    cycle_count = 0;
    pat_len = 6'd1;
    pat_bits = '0;
    clear_text();
    for (k = 0; k < 4; k++) alphabet[k] = 8'h41 + 8'(k);

    // length 1, all-zero pattern after reset
    add_beat(8'h00, 1'b0, 1'b1, match_result_t'{6'd0, 16'd1, 17'd0, 1'b1, 1'b0});
    add_beat(8'hFF, 1'b1, 1'b1, match_result_t'{6'd0, 16'd1, 17'd0, 1'b1, 1'b1});
    // first byte of a text always takes the best
    add_beat(8'hFF, 1'b1, 1'b1, match_result_t'{6'd1, 16'd1, 17'd0, 1'b0, 1'b1});
    // upper data bits ignored, length 32
    add_write(ased_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    add_beat(8'h00, 1'b1, 1'b1, match_result_t'{6'd31, 16'd1, START_MINUS_31, 1'b0, 1'b1});
    // length above range clamps to 32; worst distance
    add_write(ased_pkg::CFG_PATTERN_LENGTH, 64'd63);
    add_beat(8'h55, 1'b1, 1'b1, match_result_t'{6'd32, 16'd1, START_MINUS_31, 1'b0, 1'b1});
    // unmapped indexes must not touch the pattern; zero length acts as one
    add_write(CFG_UNMAPPED_FIRST, '1);
    add_write(CFG_UNMAPPED_LAST, '1);
    add_write(ased_pkg::CFG_PATTERN_LENGTH, 64'd0);
    add_beat(8'h00, 1'b1, 1'b1, match_result_t'{6'd0, 16'd1, 17'd0, 1'b1, 1'b1});
    add_write(ased_pkg::CFG_PATTERN_0_7, DIR_W0);
    add_write(ased_pkg::CFG_PATTERN_8_15, DIR_W1);
    add_write(ased_pkg::CFG_PATTERN_16_23, DIR_W2);
    add_write(ased_pkg::CFG_PATTERN_24_31, DIR_W3);
    add_write(ased_pkg::CFG_PATTERN_LENGTH, 64'd8);
    for (k = 0; k < 8; k++) add_beat(DIR_W0[k*8 +: 8], k == 7, 1'b0, '0);
    // length change in the middle of a text
    for (k = 0; k < 4; k++) add_beat(DIR_W0[k*8 +: 8], 1'b0, 1'b0, '0);
    add_write(ased_pkg::CFG_PATTERN_LENGTH, 64'd4);
    add_beat(DIR_W0[32 +: 8], 1'b0, 1'b0, '0);
    add_beat(DIR_W0[40 +: 8], 1'b1, 1'b0, '0);
    add_write(ased_pkg::CFG_PATTERN_LENGTH, 64'd33);
    add_beat(8'hFF, 1'b0, 1'b0, '0);
    add_beat(8'h00, 1'b1, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_register(row.idx, row.data);
      end else begin
        send_beat(row.ch, row.last, row.typed, row.exp);
      end
    end

    phase = 0;
    while (beats_sent < directed_rows.size() + RANDOM_BEATS) begin
      drain_results();
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: len_sel = 6'd0;
        1: len_sel = 6'd1;
        2: len_sel = 6'd32;
        3: len_sel = 6'($urandom_range(33, 63));
        default: len_sel = 6'($urandom_range(2, 31));
      endcase
      word = {$urandom, $urandom};
      word[5:0] = len_sel;
      write_register(ased_pkg::CFG_PATTERN_LENGTH, word);
      if (phase == 0 || $urandom_range(0, 1) == 0) begin
        small_alpha = ($urandom_range(0, 2) != 0);
        for (k = 0; k < 4; k++) alphabet[k] = 8'($urandom);
        for (k = 0; k < 4; k++) begin
          for (j = 0; j < 8; j++)
            word[j*8 +: 8] = small_alpha ? alphabet[$urandom_range(0, 3)] : 8'($urandom);
          write_register(IDX_W'(int'(ased_pkg::CFG_PATTERN_0_7) + k), word);
        end
      end
      if ($urandom_range(0, 3) == 0)
        write_register(IDX_W'($urandom_range(CFG_UNMAPPED_FIRST, CFG_UNMAPPED_LAST)),
                       {$urandom, $urandom});
      // long hold-off on the result side so the input backs up
      if (phase == 2) rx_hold_request = HOLD_CYCLES;
      m_eff = used_length();
      ntexts = $urandom_range(1, 4);
      for (t = 0; t < ntexts; t++) begin
        text_q.delete();
        if ($urandom_range(0, 9) < 7) begin
          repeat ($urandom_range(0, 5)) text_q.push_back(noise_byte());
          for (j = 0; j < m_eff; j++) begin
            pb = pat_bits[j*8 +: 8];
            sel = $urandom_range(0, 9);
            case (sel)
              0: ;
              1: text_q.push_back(noise_byte());
              2: begin
                text_q.push_back(noise_byte());
                text_q.push_back(pb);
              end
              default: text_q.push_back(pb);
            endcase
          end
          repeat ($urandom_range(0, 5)) text_q.push_back(noise_byte());
        end else begin
          repeat ($urandom_range(1, 20)) text_q.push_back(noise_byte());
        end
        if (text_q.size() == 0) text_q.push_back(noise_byte());
        // an open text carries over into the next setting
        truncate = (t == ntexts - 1) && ($urandom_range(0, 3) == 0);
        for (k = 0; k < text_q.size(); k++)
          send_beat(text_q[k], (k == text_q.size() - 1) && !truncate, 1'b0, '0);
      end
      phase++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
